// ===== rtl/spnm_pkg.sv =====
// shared types, constants and constant functions of the stable pitch note matcher
`timescale 1ns / 1ps

package spnm_pkg;

   localparam int unsigned FREQ_W      = 16;
   localparam int unsigned TS_W        = 32;
   localparam int unsigned CENTS_W     = 16;
   localparam int unsigned COUNT_W     = 8;
   localparam int unsigned NOTE_COUNT  = 6;
   localparam int unsigned NOTE_IDX_W  = 3;
   // wide enough for the highest note at the largest frequency fraction
   localparam int unsigned NOTE_W      = 17;
   localparam int unsigned CSR_W       = 16;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = 1;
   localparam int unsigned SCALE_W     = 15;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
   localparam logic [SCALE_W-1:0] CENTS_SCALE = 15'd19200;

   localparam logic [FREQ_W-1:0]  RESET_MIN_FREQ  = 16'd1120;
   localparam logic [FREQ_W-1:0]  RESET_MAX_FREQ  = 16'd6400;
   localparam logic [FREQ_W-1:0]  RESET_TOLERANCE = 16'd32;
   localparam logic [COUNT_W-1:0] RESET_REQ_READS = 8'd3;

   localparam logic [CENTS_W-1:0] CENTS_NEG_FULL = 16'h8000;
   localparam logic [CENTS_W-1:0] CENTS_POS_FULL = 16'h7fff;

   localparam int unsigned NOTE_CENTIHZ [NOTE_COUNT] = '{
      8241, 11000, 14683, 19600, 24694, 32963
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_FREQ  = 2'd0,
      CSR_MAX_FREQ  = 2'd1,
      CSR_TOLERANCE = 2'd2,
      CSR_REQ_READS = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [FREQ_W-1:0]  min_frequency;
      logic [FREQ_W-1:0]  max_frequency;
      logic [FREQ_W-1:0]  frequency_tolerance;
      logic [COUNT_W-1:0] stable_reads;
   } cfg_type;

   typedef struct packed {
      logic [TS_W-1:0]       timestamp;
      logic                  pitch_valid;
      logic [FREQ_W-1:0]     frequency;
      logic [NOTE_IDX_W-1:0] note;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_port_type;

   typedef enum logic [5:0] {
      BK_IDLE = 6'b000001,
      BK_NORM = 6'b000010,
      BK_ITER = 6'b000100,
      BK_DIFF = 6'b001000,
      BK_MUL  = 6'b010000,
      BK_SAT  = 6'b100000
   } back_state_type;

   // note frequency in input units, rounded
   function automatic logic [NOTE_W-1:0] note_units(input int unsigned idx,
                                                    input int unsigned frac_bits);
      logic [39:0] v;
      v = 40'(NOTE_CENTIHZ[idx]) << frac_bits;
      return NOTE_W'((v + 40'd50) / 40'd100);
   endfunction

   // log2 by repeated squaring, for elaboration-time constants only
   function automatic logic [63:0] log2_const(input logic [31:0] x,
                                              input int unsigned lfb);
      int unsigned msb;
      logic [63:0] y;
      logic [63:0] frac;
      msb = 0;
      while (msb < 31 && (x >> (msb + 1)) != 32'd0) msb++;
      y = 64'(x) << (31 - msb);
      frac = 64'd0;
      for (int i = 0; i < int'(lfb); i++) begin
         y = (y * y) >> 31;
         frac = frac << 1;
         if (y >= (64'd1 << 32)) begin
            frac = frac | 64'd1;
            y = y >> 1;
         end
      end
      return (64'(msb) << lfb) | frac;
   endfunction

endpackage

// ===== rtl/spnm_if.sv =====
// request and response stream interfaces of the stable pitch note matcher
`timescale 1ns / 1ps

interface spnm_req_if import spnm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] frequency_in;
   logic [TS_W-1:0]   timestamp_in;

   modport source (output valid, output frequency_in, output timestamp_in, input ready);
   modport sink (input valid, input frequency_in, input timestamp_in, output ready);
endinterface

interface spnm_rsp_if import spnm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [TS_W-1:0]       timestamp_out;
   logic                  pitch_valid;
   logic [FREQ_W-1:0]     frequency_out;
   logic [NOTE_IDX_W-1:0] note_index;
   logic [CENTS_W-1:0]    cents_deviation;

   modport source (output valid, output timestamp_out, output pitch_valid,
                   output frequency_out, output note_index, output cents_deviation,
                   input ready);
   modport sink (input valid, input timestamp_out, input pitch_valid,
                 input frequency_out, input note_index, input cents_deviation,
                 output ready);
endinterface

// ===== rtl/spnm_front.sv =====
// front end: accepts frames, tracks pitch stability and picks the nearest note
`timescale 1ns / 1ps

module spnm_front
   import spnm_pkg::*;
#(
   parameter int unsigned FREQ_FRAC_BITS = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   spnm_req_if.sink       req,
   input  logic           q_full,
   output queue_port_type push
);

   localparam logic [NOTE_W-1:0] NOTE_UNITS [NOTE_COUNT] = '{
      note_units(0, FREQ_FRAC_BITS), note_units(1, FREQ_FRAC_BITS),
      note_units(2, FREQ_FRAC_BITS), note_units(3, FREQ_FRAC_BITS),
      note_units(4, FREQ_FRAC_BITS), note_units(5, FREQ_FRAC_BITS)
   };

   logic                  hold_ff, hold_in;
   logic [FREQ_W-1:0]     freq_ff, freq_in;
   logic [TS_W-1:0]       ts_ff, ts_in;
   logic [FREQ_W-1:0]     last_ff, last_in;
   logic [COUNT_W-1:0]    count_ff, count_in;

   logic                  do_push;
   logic                  in_range;
   logic [FREQ_W-1:0]     jump;
   logic [COUNT_W-1:0]    count_next;
   logic                  report;
   logic [NOTE_W-1:0]     freq_ext;
   logic [NOTE_W-1:0]     note_gap;
   logic [NOTE_W-1:0]     best_gap;
   logic [NOTE_IDX_W-1:0] best_idx;

   assign do_push   = hold_ff && !q_full;
   assign req.ready = !hold_ff || do_push;

   always_comb begin
      in_range = (freq_ff >= cfg.min_frequency) && (freq_ff <= cfg.max_frequency);
      jump = (freq_ff >= last_ff) ? (freq_ff - last_ff) : (last_ff - freq_ff);
      if (jump <= cfg.frequency_tolerance) begin
         count_next = (count_ff == COUNT_MAX) ? count_ff : count_ff + 8'd1;
      end else begin
         count_next = 8'd1;
      end
      report = in_range && (count_next >= cfg.stable_reads);
   end

   // nearest note, ties to the lower index
   always_comb begin
      freq_ext = NOTE_W'(freq_ff);
      best_gap = (freq_ext >= NOTE_UNITS[0]) ? (freq_ext - NOTE_UNITS[0])
                                             : (NOTE_UNITS[0] - freq_ext);
      best_idx = '0;
      note_gap = '0;
      for (int i = 1; i < int'(NOTE_COUNT); i++) begin
         note_gap = (freq_ext >= NOTE_UNITS[i]) ? (freq_ext - NOTE_UNITS[i])
                                                : (NOTE_UNITS[i] - freq_ext);
         if (note_gap < best_gap) begin
            best_gap = note_gap;
            best_idx = NOTE_IDX_W'(i);
         end
      end
   end

   always_comb begin
      push.valid            = do_push;
      push.item.timestamp   = ts_ff;
      push.item.pitch_valid = report;
      push.item.frequency   = report ? freq_ff : '0;
      push.item.note        = report ? best_idx : '0;
   end

   always_comb begin
      hold_in  = hold_ff;
      freq_in  = freq_ff;
      ts_in    = ts_ff;
      last_in  = last_ff;
      count_in = count_ff;
      if (do_push) begin
         hold_in  = 1'b0;
         last_in  = in_range ? freq_ff : '0;
         count_in = in_range ? count_next : '0;
      end
      if (req.valid && req.ready) begin
         hold_in = 1'b1;
         freq_in = req.frequency_in;
         ts_in   = req.timestamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         last_ff  <= '0;
         count_ff <= '0;
      end else begin
         hold_ff  <= hold_in;
         last_ff  <= last_in;
         count_ff <= count_in;
      end
      freq_ff <= freq_in;
      ts_ff   <= ts_in;
   end

endmodule

// ===== rtl/spnm_queue.sv =====
// short queue between the front end and the cents unit
`timescale 1ns / 1ps

module spnm_queue
   import spnm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  queue_port_type push,
   output logic           full,
   output queue_port_type head,
   input  logic           pop
);

   item_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.item  = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.item;
      end
   end

endmodule

// ===== rtl/spnm_back.sv =====
// back end: iterative log2, cents deviation and the response register
`timescale 1ns / 1ps

module spnm_back
   import spnm_pkg::*;
#(
   parameter int unsigned FREQ_FRAC_BITS = 4,
   parameter int unsigned LOG_FRAC_BITS  = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  queue_port_type head,
   output logic           pop,
   spnm_rsp_if.source     rsp
);

   localparam int unsigned LW     = LOG_FRAC_BITS + 5;
   localparam int unsigned PW     = LW + SCALE_W;
   localparam int unsigned SW     = PW - LOG_FRAC_BITS;
   localparam int unsigned ITER_W = $clog2(LOG_FRAC_BITS);

   localparam logic [LW-1:0] NOTE_LOG [NOTE_COUNT] = '{
      LW'(log2_const(32'(note_units(0, FREQ_FRAC_BITS)), LOG_FRAC_BITS)),
      LW'(log2_const(32'(note_units(1, FREQ_FRAC_BITS)), LOG_FRAC_BITS)),
      LW'(log2_const(32'(note_units(2, FREQ_FRAC_BITS)), LOG_FRAC_BITS)),
      LW'(log2_const(32'(note_units(3, FREQ_FRAC_BITS)), LOG_FRAC_BITS)),
      LW'(log2_const(32'(note_units(4, FREQ_FRAC_BITS)), LOG_FRAC_BITS)),
      LW'(log2_const(32'(note_units(5, FREQ_FRAC_BITS)), LOG_FRAC_BITS))
   };

   back_state_type           state_ff, state_in;
   item_type                 item_ff, item_in;
   logic [3:0]               msb_ff, msb_in;
   logic [31:0]              y_ff, y_in;
   logic [LOG_FRAC_BITS-1:0] frac_ff, frac_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     neg_ff, neg_in;
   logic [LW-1:0]            mag_ff, mag_in;
   logic [PW-1:0]            prod_ff, prod_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   item_type                 out_ff, out_in;
   logic [CENTS_W-1:0]       cents_ff, cents_in;

   logic                     out_free;
   logic                     direct;
   logic [3:0]               lead;
   logic [63:0]              square;
   logic [32:0]              sq_q;
   logic [LW-1:0]            log_f;
   logic [LW-1:0]            log_n;
   logic [SW-1:0]            scaled;
   logic [SW-1:0]            neg_mag;
   logic [CENTS_W-1:0]       cents_sat;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign direct   = !head.item.pitch_valid || (head.item.frequency == '0);

   // leading one of the working frequency
   always_comb begin
      lead = '0;
      for (int i = 0; i < int'(FREQ_W); i++) begin
         if (item_ff.frequency[i]) begin
            lead = 4'(i);
         end
      end
   end

   assign square = y_ff * y_ff;
   assign sq_q   = square[63:31];
   assign log_f  = {1'b0, msb_ff, frac_ff};
   assign log_n  = NOTE_LOG[item_ff.note];
   assign scaled = prod_ff[PW-1:LOG_FRAC_BITS];

   always_comb begin
      neg_mag = (scaled > SW'(32768)) ? SW'(32768) : scaled;
      if (neg_ff) begin
         cents_sat = CENTS_W'(SW'(0) - neg_mag);
      end else begin
         cents_sat = (scaled > SW'(32767)) ? CENTS_POS_FULL : CENTS_W'(scaled);
      end
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      msb_in       = msb_ff;
      y_in         = y_ff;
      frac_in      = frac_ff;
      iter_in      = iter_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      prod_in      = prod_ff;
      out_in       = out_ff;
      cents_in     = cents_ff;
      rsp_valid_in = rsp.ready ? 1'b0 : rsp_valid_ff;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (head.valid) begin
               if (direct) begin
                  if (out_free) begin
                     pop          = 1'b1;
                     out_in       = head.item;
                     cents_in     = head.item.pitch_valid ? CENTS_NEG_FULL : '0;
                     rsp_valid_in = 1'b1;
                  end
               end else begin
                  pop      = 1'b1;
                  item_in  = head.item;
                  state_in = BK_NORM;
               end
            end
         end
         BK_NORM: begin
            msb_in   = lead;
            y_in     = 32'(item_ff.frequency) << (5'd31 - 5'(lead));
            frac_in  = '0;
            iter_in  = '0;
            state_in = BK_ITER;
         end
         BK_ITER: begin
            frac_in = {frac_ff[LOG_FRAC_BITS-2:0], sq_q[32]};
            y_in    = sq_q[32] ? sq_q[32:1] : sq_q[31:0];
            iter_in = iter_ff + 1'b1;
            if (iter_ff == ITER_W'(LOG_FRAC_BITS - 1)) begin
               state_in = BK_DIFF;
            end
         end
         BK_DIFF: begin
            neg_in   = log_f < log_n;
            mag_in   = (log_f < log_n) ? (log_n - log_f) : (log_f - log_n);
            state_in = BK_MUL;
         end
         BK_MUL: begin
            prod_in  = PW'(mag_ff) * PW'(CENTS_SCALE);
            state_in = BK_SAT;
         end
         BK_SAT: begin
            if (out_free) begin
               out_in       = item_ff;
               cents_in     = cents_sat;
               rsp_valid_in = 1'b1;
               state_in     = BK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff  <= item_in;
      msb_ff   <= msb_in;
      y_ff     <= y_in;
      frac_ff  <= frac_in;
      iter_ff  <= iter_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      prod_ff  <= prod_in;
      out_ff   <= out_in;
      cents_ff <= cents_in;
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.timestamp_out   = out_ff.timestamp;
   assign rsp.pitch_valid     = out_ff.pitch_valid;
   assign rsp.frequency_out   = out_ff.frequency;
   assign rsp.note_index      = out_ff.note;
   assign rsp.cents_deviation = cents_ff;

endmodule

// ===== rtl/stable_pitch_note_matcher_core.sv =====
// Path: a reported pitch with nonzero frequency passes the front-end hold register, the
// queue, back-end states NORM, ITER, DIFF, MUL, SAT and the response register; other
// frames go from the queue into the response register. Throughput: one reported pitch at
// a time, its log2 loop one bit a cycle; others one a cycle while the response is taken.
// Reset: synchronous, active high; clears stability state, queue and response register
// and restores the register defaults. No clearing pass.
`timescale 1ns / 1ps

module stable_pitch_note_matcher_core
   import spnm_pkg::*;
#(
   parameter int unsigned FREQ_FRAC_BITS = 4,
   parameter int unsigned LOG_FRAC_BITS  = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   spnm_req_if.sink             req,
   spnm_rsp_if.source           rsp,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_write_data
);

   cfg_type        cfg_ff, cfg_in;
   queue_port_type push;
   queue_port_type head;
   logic           q_full;
   logic           pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_MIN_FREQ:  cfg_in.min_frequency       = csr_write_data;
            CSR_MAX_FREQ:  cfg_in.max_frequency       = csr_write_data;
            CSR_TOLERANCE: cfg_in.frequency_tolerance = csr_write_data;
            CSR_REQ_READS: cfg_in.stable_reads        = csr_write_data[COUNT_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_frequency       <= RESET_MIN_FREQ;
         cfg_ff.max_frequency       <= RESET_MAX_FREQ;
         cfg_ff.frequency_tolerance <= RESET_TOLERANCE;
         cfg_ff.stable_reads        <= RESET_REQ_READS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spnm_front #(
      .FREQ_FRAC_BITS(FREQ_FRAC_BITS)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg_ff),
      .req   (req),
      .q_full(q_full),
      .push  (push)
   );

   spnm_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push (push),
      .full (q_full),
      .head (head),
      .pop  (pop)
   );

   spnm_back #(
      .FREQ_FRAC_BITS(FREQ_FRAC_BITS),
      .LOG_FRAC_BITS (LOG_FRAC_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .head (head),
      .pop  (pop),
      .rsp  (rsp)
   );

endmodule

// ===== rtl/spnm_checker.sv =====
// port-level checks of the stable pitch note matcher and their bind
`timescale 1ns / 1ps

module spnm_checker
   import spnm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [TS_W-1:0]       timestamp_out,
   input logic                  pitch_valid,
   input logic [FREQ_W-1:0]     frequency_out,
   input logic [NOTE_IDX_W-1:0] note_index,
   input logic [CENTS_W-1:0]    cents_deviation
);

   // response register empties on reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(timestamp_out)
         && $stable(pitch_valid) && $stable(frequency_out)
         && $stable(note_index) && $stable(cents_deviation))
      else $error("stalled response changed");

   // unreported frames carry zero fields
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !pitch_valid |-> frequency_out == '0 && note_index == '0
         && cents_deviation == '0)
      else $error("unreported frame with nonzero fields");

   // only six notes
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pitch_valid |-> note_index < NOTE_IDX_W'(NOTE_COUNT))
      else $error("note index out of range");

   // zero frequency saturates to the lowest deviation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && pitch_valid && frequency_out == '0 |-> cents_deviation == CENTS_NEG_FULL)
      else $error("zero frequency deviation not saturated");

endmodule

bind stable_pitch_note_matcher_core spnm_checker u_spnm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .timestamp_out  (rsp.timestamp_out),
   .pitch_valid    (rsp.pitch_valid),
   .frequency_out  (rsp.frequency_out),
   .note_index     (rsp.note_index),
   .cents_deviation(rsp.cents_deviation)
);
